@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL. Every module that uses them has
// clk_i and rst_ni in scope; checks are off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define PGSA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must never be seen at a rising clock edge outside reset.
`define PGSA_ASSERT_NEVER(name, cond, msg) \
  `PGSA_ASSERT(name, !(cond), msg)

`endif

@@ rtl/core/pgsa_pkg.sv @@
package pgsa_pkg;

  // Default depth of the block table.
  localparam int unsigned MaxBlocksDefault = 16;

  // Field and datapath widths.
  localparam int unsigned AddrW    = 32;
  localparam int unsigned PosW     = AddrW + 1;  // addresses up to and including 2^32
  localparam int unsigned WideW    = AddrW + 2;  // an address plus a span
  localparam int unsigned PageBits = 12;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [PageBits-1:0] PageMask  = '1;
  localparam logic [AddrW-1:0]    PageBytes = AddrW'(1) << PageBits;

  // Remainder unit: one quotient bit per step over the whole position word.
  localparam int unsigned RemSteps = PosW;
  localparam int unsigned RemCntW  = $clog2(RemSteps + 1);

  typedef enum logic [1:0] {
    KIND_FIRST_FIT = 2'd0,
    KIND_FIXED     = 2'd1,
    KIND_FREE      = 2'd2,
    KIND_QUERY     = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEG_START = 1'b0,
    CFG_SEG_SIZE  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] size;
    logic [AddrW-1:0] align;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] result_addr;
    logic             ok;
    logic [AddrW-1:0] used_bytes;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_PREP,
    S_LIMIT,
    S_BOUND,
    S_RD,
    S_CMP,
    S_DIV_GO,
    S_DIV_WAIT,
    S_ADJ,
    S_COMMIT,
    S_DONE
  } state_e;

endpackage

@@ rtl/core/page_segment_allocator_top.sv @@
// Channel | Direction | Handshake                 | Beat
// --------+-----------+---------------------------+-------------------------------
// in      | input     | in_valid_i / in_stall_o   | req_t: kind, addr, size, align
// out     | output    | out_valid_o / out_stall_i | rsp_t: result_addr, ok, used_bytes
// cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// Query goes from setup straight to the finishing step. Free reads the table entry by
// entry until it finds the address; fixed allocate tests each entry and stops at
// the first overlap. First fit walks the table once per skipped block, and an alignment
// above a page adds a pass through the remainder unit before the commit.
// Each table entry takes a read step and a compare step: the table read is registered.
// Reset clears the valid bits, the byte total and the segment registers at once; a
// finished beat waits in the output register while a new request is accepted.
`include "assert_macros.svh"

module page_segment_allocator_top import pgsa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MaxBlocksDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  req_t               in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rsp_t               out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [AddrW-1:0]   cfg_wdata_i
);

  localparam int unsigned IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_BLOCKS - 1);

  state_e state_q, state_d;

  // Configuration and persistent bookkeeping.
  logic [AddrW-1:0]      seg_start_q, seg_size_q;
  logic [AddrW-1:0]      used_q, used_d;
  logic [MAX_BLOCKS-1:0] valid_q, valid_d;

  // Block table. Entries are meaningful only while their valid bit is set.
  logic [AddrW-1:0] mem_start [MAX_BLOCKS];
  logic [AddrW-1:0] mem_len   [MAX_BLOCKS];
  logic             mem_we;

  // Request working registers.
  req_t             req_q, req_d;
  logic [PosW-1:0]  end_q, end_d;
  logic [PosW-1:0]  len_q, len_d;
  logic [AddrW-1:0] alen_q, alen_d;
  logic [AddrW-1:0] extra_q, extra_d;
  logic [WideW-1:0] span_q, span_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [WideW-1:0] hi_q, hi_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [IdxW-1:0]  slot_q, slot_d;
  logic             full_q, full_d;
  logic [AddrW-1:0] delta_q, delta_d;
  logic [AddrW-1:0] res_addr_q, res_addr_d;
  logic             res_ok_q, res_ok_d;
  logic [AddrW-1:0] rd_start_q, rd_len_q;
  logic             rd_valid_q;

  // Output register.
  rsp_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  // Remainder unit for first-fit alignment.
  logic             rem_start;
  logic             rem_done;
  logic [AddrW-1:0] rem_val;

  // Combinational helpers.
  logic [IdxW-1:0]  free_slot;
  logic             table_full;
  logic [PosW-1:0]  seg_sum;
  logic [WideW-1:0] round_sum;
  logic [PosW-1:0]  blk_end;
  logic             ovl_hit;
  logic             free_hit;
  logic             in_accept;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // Lowest free table slot.
  always_comb begin
    free_slot  = '0;
    table_full = 1'b1;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot  = IdxW'(i);
        table_full = 1'b0;
      end
    end
  end

  assign seg_sum   = {1'b0, seg_start_q} + {1'b0, seg_size_q};
  assign round_sum = {1'b0, len_q} + WideW'(PageMask);
  assign blk_end   = {1'b0, rd_start_q} + {1'b0, rd_len_q};
  assign ovl_hit   = rd_valid_q && ({2'b00, rd_start_q} < hi_q) && (pos_q < blk_end);
  assign free_hit  = rd_valid_q && (rd_start_q == req_q.addr);

  pgsa_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (pos_q),
    .divisor_i  (alen_q),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    valid_d     = valid_q;
    req_d       = req_q;
    end_d       = end_q;
    len_d       = len_q;
    alen_d      = alen_q;
    extra_d     = extra_q;
    span_d      = span_q;
    pos_d       = pos_q;
    hi_d        = hi_q;
    idx_d       = idx_q;
    slot_d      = slot_q;
    full_d      = full_q;
    delta_d     = delta_q;
    res_addr_d  = res_addr_q;
    res_ok_d    = res_ok_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    rem_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          req_d   = in_data_i;
          state_d = S_SETUP;
        end
      end

      S_SETUP: begin
        // The segment ends at start + size, but never beyond 2^32.
        if (seg_sum[PosW-1] && (|seg_sum[AddrW-1:0])) begin
          end_d = PosW'(1) << AddrW;
        end else begin
          end_d = seg_sum;
        end
        slot_d     = free_slot;
        full_d     = table_full;
        res_addr_d = '0;
        res_ok_d   = 1'b0;
        idx_d      = '0;
        case (kind_e'(req_q.kind))
          KIND_QUERY: begin
            res_ok_d = 1'b1;
            state_d  = S_DONE;
          end
          KIND_FREE: begin
            state_d = S_RD;
          end
          KIND_FIXED: begin
            // An unaligned start drops to its page and the length grows by the cut.
            len_d   = {1'b0, req_q.size} + PosW'(req_q.addr[PageBits-1:0]);
            pos_d   = {1'b0, req_q.addr[AddrW-1:PageBits], {PageBits{1'b0}}};
            state_d = S_PREP;
          end
          default: begin
            len_d   = {1'b0, req_q.size};
            pos_d   = {1'b0, seg_start_q};
            state_d = S_PREP;
          end
        endcase
      end

      S_PREP: begin
        len_d = round_sum[PosW-1:0] & ~PosW'(PageMask);
        if ((kind_e'(req_q.kind) == KIND_FIRST_FIT) && (req_q.align > PageBytes)) begin
          alen_d  = {req_q.align[AddrW-1:PageBits], {PageBits{1'b0}}};
          extra_d = {req_q.align[AddrW-1:PageBits], {PageBits{1'b0}}} - AddrW'(1);
        end else begin
          alen_d  = '0;
          extra_d = '0;
        end
        state_d = S_LIMIT;
      end

      S_LIMIT: begin
        span_d = {1'b0, len_q} + WideW'(extra_q);
        if ((len_q == '0) || full_q ||
            ((kind_e'(req_q.kind) == KIND_FIXED) && (pos_q < {1'b0, seg_start_q}))) begin
          state_d = S_DONE;
        end else begin
          state_d = S_BOUND;
        end
      end

      S_BOUND: begin
        // Candidate range [pos, pos + span) must end inside the segment.
        hi_d  = {1'b0, pos_q} + span_q;
        idx_d = '0;
        if (({1'b0, pos_q} + span_q) > {1'b0, end_q}) begin
          state_d = S_DONE;
        end else begin
          state_d = S_RD;
        end
      end

      S_RD: begin
        state_d = S_CMP;
      end

      S_CMP: begin
        idx_d = idx_q + IdxW'(1);
        if (kind_e'(req_q.kind) == KIND_FREE) begin
          if (free_hit) begin
            valid_d[idx_q] = 1'b0;
            used_d         = used_q - rd_len_q;
            res_ok_d       = 1'b1;
            state_d        = S_DONE;
          end else if (idx_q == LastIdx) begin
            state_d = S_DONE;
          end else begin
            state_d = S_RD;
          end
        end else if (ovl_hit) begin
          if (kind_e'(req_q.kind) == KIND_FIXED) begin
            state_d = S_DONE;
          end else begin
            // Jump past the blocking entry and test the whole table again.
            pos_d   = blk_end;
            state_d = S_BOUND;
          end
        end else if (idx_q == LastIdx) begin
          if (alen_q != '0) begin
            state_d = S_DIV_GO;
          end else begin
            state_d = S_COMMIT;
          end
        end else begin
          state_d = S_RD;
        end
      end

      S_DIV_GO: begin
        rem_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end

      S_DIV_WAIT: begin
        if (rem_done) begin
          delta_d = (rem_val == '0) ? '0 : (alen_q - rem_val);
          state_d = S_ADJ;
        end
      end

      S_ADJ: begin
        pos_d   = pos_q + PosW'(delta_q);
        state_d = S_COMMIT;
      end

      S_COMMIT: begin
        mem_we          = 1'b1;
        valid_d[slot_q] = 1'b1;
        used_d          = used_q + len_q[AddrW-1:0];
        res_addr_d      = pos_q[AddrW-1:0];
        res_ok_d        = 1'b1;
        state_d         = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.result_addr = res_ok_q ? res_addr_q : '0;
          out_d.ok          = res_ok_q;
          out_d.used_bytes  = used_q;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      seg_start_q <= '0;
      seg_size_q  <= '0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_SEG_START: seg_start_q <= cfg_wdata_i;
          CFG_SEG_SIZE:  seg_size_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    end_q      <= end_d;
    len_q      <= len_d;
    alen_q     <= alen_d;
    extra_q    <= extra_d;
    span_q     <= span_d;
    pos_q      <= pos_d;
    hi_q       <= hi_d;
    idx_q      <= idx_d;
    slot_q     <= slot_d;
    full_q     <= full_d;
    delta_q    <= delta_d;
    res_addr_q <= res_addr_d;
    res_ok_q   <= res_ok_d;
    out_q      <= out_d;
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_start[slot_q] <= pos_q[AddrW-1:0];
      mem_len[slot_q]   <= len_q[AddrW-1:0];
    end
    if (state_q == S_RD) begin
      rd_start_q <= mem_start[idx_q];
      rd_len_q   <= mem_len[idx_q];
      rd_valid_q <= valid_q[idx_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A refused request never reports an address.
  `PGSA_ASSERT(a_fail_addr_zero,
               out_valid_o && !out_data_o.ok |-> out_data_o.result_addr == '0,
               "refused request carries a nonzero address")

  // A new block is never written over a live one.
  `PGSA_ASSERT_NEVER(a_commit_live_slot, state_q == S_COMMIT && valid_q[slot_q],
                     "allocation committed into a slot that is in use")

  // An accepted request always starts its setup step next.
  `PGSA_ASSERT(a_accept_setup, in_accept |=> state_q == S_SETUP,
               "accepted request did not enter setup")

  // The output register is loaded only from the finishing step.
  `PGSA_ASSERT(a_load_from_done, $rose(out_valid_o) |-> $past(state_q) == S_DONE,
               "result beat appeared outside the finishing step")

endmodule

@@ rtl/core/pgsa_rem_unit.sv @@
// Iterative restoring remainder: one dividend bit per cycle.
module pgsa_rem_unit import pgsa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [PosW-1:0]  dividend_i,
  input  logic [AddrW-1:0] divisor_i,
  output logic             done_o,
  output logic [AddrW-1:0] rem_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [RemCntW-1:0] cnt_q, cnt_d;
  logic [PosW-1:0]    num_q, num_d;
  logic [AddrW-1:0]   div_q, div_d;
  logic [AddrW-1:0]   rem_q, rem_d;
  logic [PosW-1:0]    shifted;
  logic [PosW-1:0]    diff;

  assign shifted = {rem_q, num_q[PosW-1]};
  assign diff    = shifted - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = RemCntW'(RemSteps);
      num_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (shifted >= {1'b0, div_q}) begin
        rem_d = diff[AddrW-1:0];
      end else begin
        rem_d = shifted[AddrW-1:0];
      end
      cnt_d = cnt_q - RemCntW'(1);
      if (cnt_q == RemCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
